// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the recolour unit rtl
// no dependencies; included by modules that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");

// condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error("forbidden condition");

`endif

// ===== hw/rtl/gccr_pkg.sv =====
// types and constants for the greedy clique colouring recolour unit
// no dependencies; used by gccr_ctrl, gccr_dp and the top level
package gccr_pkg;

	localparam int VERTEX_W = 6;
	localparam int ROW_W    = 64;
	localparam int COLOR_W  = 7;
	localparam int GAP_W    = 6;
	localparam int CMP_W    = 7;

	typedef struct packed {
		logic [VERTEX_W-1:0] vertex_id;
		logic [ROW_W-1:0]    adjacency_row;
		logic                order_end;
	} item_t;

	typedef struct packed {
		logic [VERTEX_W-1:0] out_vertex;
		logic [COLOR_W-1:0]  out_color;
		logic                out_last;
	} result_t;

	typedef struct packed {
		logic              recolor_enable;
		logic [GAP_W-1:0]  clique_gap;
	} cfg_t;

	// steps of a repair move
	typedef enum logic [2:0] {
		PH_RM_V,
		PH_RM_W,
		PH_AP_V,
		PH_AP_W,
		PH_RB_C,
		PH_RB_N,
		PH_RB_NX,
		PH_END
	} phase_t;

	typedef enum logic [1:0] {
		PK_REMOVE,
		PK_APPEND,
		PK_REBUILD,
		PK_DONE
	} ph_kind_t;

	typedef enum logic [5:0] {
		OP_IDLE,
		OP_LOAD,
		OP_START,
		OP_INFO_C,
		OP_FF_NEXT,
		OP_PLACE,
		OP_INFO_N,
		OP_LEN,
		OP_SCAN_RD,
		OP_SCAN_CHK,
		OP_N_NEXT,
		OP_W_ADJ,
		OP_INFO_NX,
		OP_NX_NEXT,
		OP_PH_INIT,
		OP_INFO_PH,
		OP_PH_RD,
		OP_RM_NEXT,
		OP_SH_RD,
		OP_SH_WR,
		OP_RM_END,
		OP_PH_SKIP,
		OP_AP_WR,
		OP_RB_ACC,
		OP_RB_END,
		OP_INFO_TOP,
		OP_DROP,
		OP_EM_INIT,
		OP_INFO_EC,
		OP_EM_RD,
		OP_EM_OUT,
		OP_EC_NEXT,
		OP_CLEAR
	} op_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_CHECK,
		S_FF_RD,
		S_FF_CHK,
		S_RP_NRD,
		S_RP_NLEN,
		S_RP_MRD,
		S_RP_MCHK,
		S_RP_NEVAL,
		S_RP_XRD,
		S_RP_XCHK,
		S_MV_NEXT,
		S_MV_RD,
		S_MV_LEN,
		S_RM_RD,
		S_RM_CHK,
		S_SH,
		S_SH_WR,
		S_RB_RD,
		S_RB_ACC,
		S_DROP_RD,
		S_DROP,
		S_EM_INIT,
		S_EM_CRD,
		S_EM_CLEN,
		S_EM_MRD,
		S_EM_OUT
	} state_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic     item_ok;
		logic     item_end;
		logic     ff_go_on;
		logic     rp_go;
		logic     n_done;
		logic     scan_done;
		logic     cnt_one;
		logic     nx_over;
		logic     nx_conflict;
		logic     found;
		logic     sh_last;
		ph_kind_t ph_kind;
		logic     top_empty;
		logic     held_zero;
		logic     ec_last;
		logic     out_free;
	} status_t;

endpackage

// ===== hw/rtl/greedy_clique_coloring_recolor_unit.sv =====
// greedy colouring with clique-gap recolour: one request at a time, classes emitted on order end
// a vertex is placed by first fit, which probes classes in turn from class 0
// a repair scans the members of each lower class, tries later classes and then drops the
// top class if it is empty; a move walks the list entries touched by its steps
// emission: walks each class up to the top class and each vertex in it, gated by result_ready
// reset clears control and class valid bits at once; no clearing pass, rows and lists undefined
module greedy_clique_coloring_recolor_unit #(
	parameter int MAX_VERTICES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  gccr_pkg::item_t     item,
	output logic                result_valid,
	input  logic                result_ready,
	output gccr_pkg::result_t   result,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	localparam logic REG_RECOLOR_ENABLE = 1'b0;
	localparam logic REG_CLIQUE_GAP     = 1'b1;

	gccr_pkg::cfg_t    cfg_q;
	gccr_pkg::cmd_t    cmd;
	gccr_pkg::status_t status;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_RECOLOR_ENABLE: cfg_q.recolor_enable <= pwdata[0];
				REG_CLIQUE_GAP:     cfg_q.clique_gap <= pwdata[gccr_pkg::GAP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_RECOLOR_ENABLE: prdata = {31'd0, cfg_q.recolor_enable};
			REG_CLIQUE_GAP:     prdata = {{(32 - gccr_pkg::GAP_W){1'b0}}, cfg_q.clique_gap};
			default:            prdata = '0;
		endcase
	end

	gccr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.status     (status),
		.cmd        (cmd)
	);

	gccr_dp #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.cfg          (cfg_q),
		.cmd          (cmd),
		.status       (status),
		.result_ready (result_ready),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

// ===== hw/rtl/gccr_ctrl.sv =====
// sequencer of the recolour unit: first fit, repair walk, move steps, emission
// depends on gccr_pkg; drives gccr_dp through cmd_t and reads status_t
module gccr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  gccr_pkg::status_t   status,
	output gccr_pkg::cmd_t      cmd
);

	gccr_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gccr_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gccr_pkg::S_IDLE: begin
				if (item_valid) state_d = gccr_pkg::S_CHECK;
			end
			gccr_pkg::S_CHECK: begin
				if (status.item_ok) state_d = gccr_pkg::S_FF_RD;
				else if (status.item_end) state_d = gccr_pkg::S_EM_INIT;
				else state_d = gccr_pkg::S_IDLE;
			end
			gccr_pkg::S_FF_RD: state_d = gccr_pkg::S_FF_CHK;
			gccr_pkg::S_FF_CHK: begin
				if (status.ff_go_on) state_d = gccr_pkg::S_FF_RD;
				else if (status.rp_go) state_d = gccr_pkg::S_RP_NRD;
				else if (status.item_end) state_d = gccr_pkg::S_EM_INIT;
				else state_d = gccr_pkg::S_IDLE;
			end
			gccr_pkg::S_RP_NRD: begin
				if (status.n_done) state_d = gccr_pkg::S_DROP_RD;
				else state_d = gccr_pkg::S_RP_NLEN;
			end
			gccr_pkg::S_RP_NLEN: state_d = gccr_pkg::S_RP_MRD;
			gccr_pkg::S_RP_MRD: begin
				if (status.scan_done) state_d = gccr_pkg::S_RP_NEVAL;
				else state_d = gccr_pkg::S_RP_MCHK;
			end
			gccr_pkg::S_RP_MCHK: state_d = gccr_pkg::S_RP_MRD;
			gccr_pkg::S_RP_NEVAL: begin
				if (status.cnt_one) state_d = gccr_pkg::S_RP_XRD;
				else state_d = gccr_pkg::S_RP_NRD;
			end
			gccr_pkg::S_RP_XRD: begin
				if (status.nx_over) state_d = gccr_pkg::S_RP_NRD;
				else state_d = gccr_pkg::S_RP_XCHK;
			end
			gccr_pkg::S_RP_XCHK: begin
				if (status.nx_conflict) state_d = gccr_pkg::S_RP_XRD;
				else state_d = gccr_pkg::S_MV_NEXT;
			end
			gccr_pkg::S_MV_NEXT: begin
				if (status.ph_kind == gccr_pkg::PK_DONE) state_d = gccr_pkg::S_DROP_RD;
				else state_d = gccr_pkg::S_MV_RD;
			end
			gccr_pkg::S_MV_RD: state_d = gccr_pkg::S_MV_LEN;
			gccr_pkg::S_MV_LEN: begin
				unique case (status.ph_kind)
					gccr_pkg::PK_REMOVE:  state_d = gccr_pkg::S_RM_RD;
					gccr_pkg::PK_REBUILD: state_d = gccr_pkg::S_RB_RD;
					default:              state_d = gccr_pkg::S_MV_NEXT;
				endcase
			end
			gccr_pkg::S_RM_RD: begin
				if (status.scan_done) state_d = gccr_pkg::S_MV_NEXT;
				else state_d = gccr_pkg::S_RM_CHK;
			end
			gccr_pkg::S_RM_CHK: begin
				if (status.found) state_d = gccr_pkg::S_SH;
				else state_d = gccr_pkg::S_RM_RD;
			end
			gccr_pkg::S_SH: begin
				if (status.sh_last) state_d = gccr_pkg::S_MV_NEXT;
				else state_d = gccr_pkg::S_SH_WR;
			end
			gccr_pkg::S_SH_WR: state_d = gccr_pkg::S_SH;
			gccr_pkg::S_RB_RD: begin
				if (status.scan_done) state_d = gccr_pkg::S_MV_NEXT;
				else state_d = gccr_pkg::S_RB_ACC;
			end
			gccr_pkg::S_RB_ACC: state_d = gccr_pkg::S_RB_RD;
			gccr_pkg::S_DROP_RD: state_d = gccr_pkg::S_DROP;
			gccr_pkg::S_DROP: begin
				if (status.item_end) state_d = gccr_pkg::S_EM_INIT;
				else state_d = gccr_pkg::S_IDLE;
			end
			gccr_pkg::S_EM_INIT: begin
				if (status.held_zero) state_d = gccr_pkg::S_IDLE;
				else state_d = gccr_pkg::S_EM_CRD;
			end
			gccr_pkg::S_EM_CRD: state_d = gccr_pkg::S_EM_CLEN;
			gccr_pkg::S_EM_CLEN: state_d = gccr_pkg::S_EM_MRD;
			gccr_pkg::S_EM_MRD: begin
				if (status.scan_done) begin
					if (status.ec_last) state_d = gccr_pkg::S_IDLE;
					else state_d = gccr_pkg::S_EM_CRD;
				end else if (status.out_free) begin
					state_d = gccr_pkg::S_EM_OUT;
				end
			end
			gccr_pkg::S_EM_OUT: state_d = gccr_pkg::S_EM_MRD;
			default: state_d = gccr_pkg::S_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd.op     = gccr_pkg::OP_IDLE;
		item_ready = 1'b0;
		unique case (state_q)
			gccr_pkg::S_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) cmd.op = gccr_pkg::OP_LOAD;
			end
			gccr_pkg::S_CHECK: begin
				if (status.item_ok) cmd.op = gccr_pkg::OP_START;
			end
			gccr_pkg::S_FF_RD: cmd.op = gccr_pkg::OP_INFO_C;
			gccr_pkg::S_FF_CHK: begin
				if (status.ff_go_on) cmd.op = gccr_pkg::OP_FF_NEXT;
				else cmd.op = gccr_pkg::OP_PLACE;
			end
			gccr_pkg::S_RP_NRD: begin
				if (!status.n_done) cmd.op = gccr_pkg::OP_INFO_N;
			end
			gccr_pkg::S_RP_NLEN: cmd.op = gccr_pkg::OP_LEN;
			gccr_pkg::S_RP_MRD: begin
				if (!status.scan_done) cmd.op = gccr_pkg::OP_SCAN_RD;
			end
			gccr_pkg::S_RP_MCHK: cmd.op = gccr_pkg::OP_SCAN_CHK;
			gccr_pkg::S_RP_NEVAL: begin
				if (status.cnt_one) cmd.op = gccr_pkg::OP_W_ADJ;
				else cmd.op = gccr_pkg::OP_N_NEXT;
			end
			gccr_pkg::S_RP_XRD: begin
				if (status.nx_over) cmd.op = gccr_pkg::OP_N_NEXT;
				else cmd.op = gccr_pkg::OP_INFO_NX;
			end
			gccr_pkg::S_RP_XCHK: begin
				if (status.nx_conflict) cmd.op = gccr_pkg::OP_NX_NEXT;
				else cmd.op = gccr_pkg::OP_PH_INIT;
			end
			gccr_pkg::S_MV_NEXT: cmd.op = gccr_pkg::OP_IDLE;
			gccr_pkg::S_MV_RD: cmd.op = gccr_pkg::OP_INFO_PH;
			gccr_pkg::S_MV_LEN: begin
				if (status.ph_kind == gccr_pkg::PK_APPEND) cmd.op = gccr_pkg::OP_AP_WR;
				else cmd.op = gccr_pkg::OP_LEN;
			end
			gccr_pkg::S_RM_RD: begin
				if (status.scan_done) cmd.op = gccr_pkg::OP_PH_SKIP;
				else cmd.op = gccr_pkg::OP_PH_RD;
			end
			gccr_pkg::S_RM_CHK: begin
				if (!status.found) cmd.op = gccr_pkg::OP_RM_NEXT;
			end
			gccr_pkg::S_SH: begin
				if (status.sh_last) cmd.op = gccr_pkg::OP_RM_END;
				else cmd.op = gccr_pkg::OP_SH_RD;
			end
			gccr_pkg::S_SH_WR: cmd.op = gccr_pkg::OP_SH_WR;
			gccr_pkg::S_RB_RD: begin
				if (status.scan_done) cmd.op = gccr_pkg::OP_RB_END;
				else cmd.op = gccr_pkg::OP_PH_RD;
			end
			gccr_pkg::S_RB_ACC: cmd.op = gccr_pkg::OP_RB_ACC;
			gccr_pkg::S_DROP_RD: cmd.op = gccr_pkg::OP_INFO_TOP;
			gccr_pkg::S_DROP: begin
				if (status.top_empty) cmd.op = gccr_pkg::OP_DROP;
			end
			gccr_pkg::S_EM_INIT: begin
				if (status.held_zero) cmd.op = gccr_pkg::OP_CLEAR;
				else cmd.op = gccr_pkg::OP_EM_INIT;
			end
			gccr_pkg::S_EM_CRD: cmd.op = gccr_pkg::OP_INFO_EC;
			gccr_pkg::S_EM_CLEN: cmd.op = gccr_pkg::OP_LEN;
			gccr_pkg::S_EM_MRD: begin
				if (status.scan_done) begin
					if (status.ec_last) cmd.op = gccr_pkg::OP_CLEAR;
					else cmd.op = gccr_pkg::OP_EC_NEXT;
				end else if (status.out_free) begin
					cmd.op = gccr_pkg::OP_EM_RD;
				end
			end
			gccr_pkg::S_EM_OUT: cmd.op = gccr_pkg::OP_EM_OUT;
			default: cmd.op = gccr_pkg::OP_IDLE;
		endcase
	end

endmodule

// ===== hw/rtl/gccr_dp.sv =====
// datapath of the recolour unit: class lists, class lengths and masks, rows, result register
// depends on gccr_pkg and assert_macros.svh; commanded by gccr_ctrl
`include "assert_macros.svh"

module gccr_dp #(
	parameter int MAX_VERTICES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  gccr_pkg::item_t     item,
	input  gccr_pkg::cfg_t      cfg,
	input  gccr_pkg::cmd_t      cmd,
	output gccr_pkg::status_t   status,
	input  logic                result_ready,
	output logic                result_valid,
	output gccr_pkg::result_t   result
);

	localparam int CW        = $clog2(MAX_VERTICES);
	localparam int LW        = CW + 1;
	localparam int MEM_DEPTH = 1 << (2 * CW);
	localparam logic [gccr_pkg::ROW_W-1:0] ROW_MASK =
		{gccr_pkg::ROW_W{1'b1}} >> (gccr_pkg::ROW_W - MAX_VERTICES);
	localparam logic [LW-1:0] MAX_LEN    = LW'(MAX_VERTICES);
	localparam logic [CW-1:0] LAST_CLASS = CW'(MAX_VERTICES - 1);

	// working registers
	logic [gccr_pkg::VERTEX_W-1:0] v_q, w_q;
	logic [gccr_pkg::ROW_W-1:0]    row_q, acc_q;
	logic                          end_q;
	logic [CW-1:0]                 c_q, ec_q, top_q;
	logic [LW-1:0]                 n_q, nx_q, idx_q, len_q, ecnt_q, held_q;
	logic [1:0]                    cnt_q;
	gccr_pkg::phase_t              ph_q;
	logic [MAX_VERTICES-1:0]       cvalid_q;
	gccr_pkg::result_t             res_q;
	logic                          res_vld_q;

	// stores
	logic [gccr_pkg::ROW_W-1:0]    adj_mem_q [MAX_VERTICES];
	logic [gccr_pkg::VERTEX_W-1:0] mem_q [MEM_DEPTH];
	logic [LW-1:0]                 len_mem_q [MAX_VERTICES];
	logic [gccr_pkg::ROW_W-1:0]    mask_mem_q [MAX_VERTICES];
	logic [gccr_pkg::ROW_W-1:0]    adj_rd_q, info_mask_rd_q;
	logic [gccr_pkg::VERTEX_W-1:0] mem_rd_q;
	logic [LW-1:0]                 info_len_rd_q;
	logic                          info_vld_rd_q;

	logic [LW-1:0]                 len_eff;
	logic [gccr_pkg::ROW_W-1:0]    mask_eff;
	logic [CW-1:0]                 phcls;
	logic [gccr_pkg::VERTEX_W-1:0] phval;
	logic                          info_re, info_we, mem_re, mem_we;
	logic [CW-1:0]                 info_raddr, info_waddr;
	logic [LW-1:0]                 info_wlen;
	logic [gccr_pkg::ROW_W-1:0]    info_wmask;
	logic [2*CW-1:0]               mem_raddr, mem_waddr;
	logic [gccr_pkg::VERTEX_W-1:0] mem_wdata;
	logic [LW-1:0]                 idx_inc;
	logic                          ap_room;

	assign len_eff  = info_vld_rd_q ? info_len_rd_q : '0;
	assign mask_eff = info_vld_rd_q ? info_mask_rd_q : '0;
	assign idx_inc  = idx_q + LW'(1);
	assign ap_room  = len_eff < MAX_LEN;

	always_comb begin
		unique case (ph_q)
			gccr_pkg::PH_RM_V, gccr_pkg::PH_RB_C:  phcls = c_q;
			gccr_pkg::PH_RM_W, gccr_pkg::PH_AP_V,
			gccr_pkg::PH_RB_N:                     phcls = n_q[CW-1:0];
			gccr_pkg::PH_AP_W, gccr_pkg::PH_RB_NX: phcls = nx_q[CW-1:0];
			default:                               phcls = c_q;
		endcase
		unique case (ph_q)
			gccr_pkg::PH_RM_W, gccr_pkg::PH_AP_W: phval = w_q;
			default:                              phval = v_q;
		endcase
	end

	// store port selection
	always_comb begin
		info_re    = 1'b0;
		info_raddr = c_q;
		info_we    = 1'b0;
		info_waddr = phcls;
		info_wlen  = len_eff;
		info_wmask = mask_eff;
		mem_re     = 1'b0;
		mem_raddr  = {phcls, idx_q[CW-1:0]};
		mem_we     = 1'b0;
		mem_waddr  = {phcls, idx_q[CW-1:0]};
		mem_wdata  = mem_rd_q;
		unique case (cmd.op)
			gccr_pkg::OP_INFO_C: begin
				info_re = 1'b1;
			end
			gccr_pkg::OP_INFO_N: begin
				info_re    = 1'b1;
				info_raddr = n_q[CW-1:0];
			end
			gccr_pkg::OP_INFO_NX: begin
				info_re    = 1'b1;
				info_raddr = nx_q[CW-1:0];
			end
			gccr_pkg::OP_INFO_PH: begin
				info_re    = 1'b1;
				info_raddr = phcls;
			end
			gccr_pkg::OP_INFO_TOP: begin
				info_re    = 1'b1;
				info_raddr = top_q;
			end
			gccr_pkg::OP_INFO_EC: begin
				info_re    = 1'b1;
				info_raddr = ec_q;
			end
			gccr_pkg::OP_PLACE: begin
				info_we    = 1'b1;
				info_waddr = c_q;
				info_wlen  = len_eff + LW'(1);
				info_wmask = mask_eff | (gccr_pkg::ROW_W'(1) << v_q);
				mem_we     = 1'b1;
				mem_waddr  = {c_q, len_eff[CW-1:0]};
				mem_wdata  = v_q;
			end
			gccr_pkg::OP_RM_END: begin
				info_we   = 1'b1;
				info_wlen = len_q - LW'(1);
			end
			gccr_pkg::OP_AP_WR: begin
				info_we   = ap_room;
				info_wlen = len_eff + LW'(1);
				mem_we    = ap_room;
				mem_waddr = {phcls, len_eff[CW-1:0]};
				mem_wdata = phval;
			end
			gccr_pkg::OP_RB_END: begin
				info_we    = 1'b1;
				info_wlen  = len_q;
				info_wmask = acc_q;
			end
			gccr_pkg::OP_SCAN_RD: begin
				mem_re    = 1'b1;
				mem_raddr = {n_q[CW-1:0], idx_q[CW-1:0]};
			end
			gccr_pkg::OP_PH_RD: begin
				mem_re = 1'b1;
			end
			gccr_pkg::OP_SH_RD: begin
				mem_re    = 1'b1;
				mem_raddr = {phcls, idx_inc[CW-1:0]};
			end
			gccr_pkg::OP_SH_WR: begin
				mem_we = 1'b1;
			end
			gccr_pkg::OP_EM_RD: begin
				mem_re    = 1'b1;
				mem_raddr = {ec_q, idx_q[CW-1:0]};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.op == gccr_pkg::OP_START) adj_mem_q[v_q[CW-1:0]] <= row_q;
		if (cmd.op == gccr_pkg::OP_W_ADJ) adj_rd_q <= adj_mem_q[w_q[CW-1:0]];
		if (mem_we) mem_q[mem_waddr] <= mem_wdata;
		if (mem_re) mem_rd_q <= mem_q[mem_raddr];
		if (info_we) begin
			len_mem_q[info_waddr]  <= info_wlen;
			mask_mem_q[info_waddr] <= info_wmask;
		end
		if (info_re) begin
			info_len_rd_q  <= len_mem_q[info_raddr];
			info_mask_rd_q <= mask_mem_q[info_raddr];
			info_vld_rd_q  <= cvalid_q[info_raddr];
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			gccr_pkg::OP_LOAD: begin
				v_q   <= item.vertex_id;
				row_q <= item.adjacency_row & ROW_MASK;
				end_q <= item.order_end;
			end
			gccr_pkg::OP_START:   c_q <= '0;
			gccr_pkg::OP_FF_NEXT: c_q <= c_q + CW'(1);
			gccr_pkg::OP_PLACE:   n_q <= '0;
			gccr_pkg::OP_LEN: begin
				len_q <= len_eff;
				idx_q <= '0;
				cnt_q <= '0;
				acc_q <= '0;
			end
			gccr_pkg::OP_SCAN_CHK: begin
				if (row_q[mem_rd_q]) begin
					if (cnt_q != 2'd2) cnt_q <= cnt_q + 2'd1;
					w_q <= mem_rd_q;
				end
				idx_q <= idx_inc;
			end
			gccr_pkg::OP_N_NEXT:  n_q <= n_q + LW'(1);
			gccr_pkg::OP_W_ADJ:   nx_q <= n_q + LW'(1);
			gccr_pkg::OP_NX_NEXT: nx_q <= nx_q + LW'(1);
			gccr_pkg::OP_RM_NEXT, gccr_pkg::OP_SH_WR: idx_q <= idx_inc;
			gccr_pkg::OP_RB_ACC: begin
				acc_q <= acc_q | (gccr_pkg::ROW_W'(1) << mem_rd_q);
				idx_q <= idx_inc;
			end
			gccr_pkg::OP_EM_INIT: begin
				ec_q   <= '0;
				ecnt_q <= '0;
			end
			gccr_pkg::OP_EM_OUT: begin
				idx_q  <= idx_inc;
				ecnt_q <= ecnt_q + LW'(1);
				res_q  <= '{out_vertex: mem_rd_q,
					out_color: gccr_pkg::COLOR_W'(ec_q) + gccr_pkg::COLOR_W'(1),
					out_last: (ecnt_q == held_q - LW'(1))};
			end
			gccr_pkg::OP_EC_NEXT: ec_q <= ec_q + CW'(1);
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q     <= '0;
			held_q    <= '0;
			cvalid_q  <= '0;
			res_vld_q <= 1'b0;
			ph_q      <= gccr_pkg::PH_RM_V;
		end else begin
			if (cmd.op == gccr_pkg::OP_EM_OUT) res_vld_q <= 1'b1;
			else if (result_ready) res_vld_q <= 1'b0;
			if (info_we) cvalid_q[info_waddr] <= 1'b1;
			unique case (cmd.op)
				gccr_pkg::OP_PLACE: begin
					held_q <= held_q + LW'(1);
					if (c_q > top_q) top_q <= c_q;
				end
				gccr_pkg::OP_DROP:    top_q <= top_q - CW'(1);
				gccr_pkg::OP_PH_INIT: ph_q <= gccr_pkg::PH_RM_V;
				gccr_pkg::OP_RM_END, gccr_pkg::OP_PH_SKIP,
				gccr_pkg::OP_AP_WR, gccr_pkg::OP_RB_END:
					ph_q <= gccr_pkg::phase_t'(ph_q + 3'd1);
				gccr_pkg::OP_CLEAR: begin
					top_q    <= '0;
					held_q   <= '0;
					cvalid_q <= '0;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		status.item_ok     = (gccr_pkg::CMP_W'(v_q) < gccr_pkg::CMP_W'(MAX_VERTICES)) &&
			(held_q < MAX_LEN);
		status.item_end    = end_q;
		status.ff_go_on    = (c_q < LAST_CLASS) && (len_eff != '0) && ((row_q & mask_eff) != '0);
		status.rp_go       = cfg.recolor_enable && (cfg.clique_gap != '0) &&
			(gccr_pkg::CMP_W'(c_q) >= gccr_pkg::CMP_W'(cfg.clique_gap)) && (c_q >= top_q);
		status.n_done      = gccr_pkg::CMP_W'(n_q) >= gccr_pkg::CMP_W'(cfg.clique_gap);
		status.scan_done   = idx_q == len_q;
		status.cnt_one     = cnt_q == 2'd1;
		status.nx_over     = gccr_pkg::CMP_W'(nx_q) > gccr_pkg::CMP_W'(cfg.clique_gap);
		status.nx_conflict = (adj_rd_q & mask_eff) != '0;
		status.found       = mem_rd_q == phval;
		status.sh_last     = idx_inc == len_q;
		unique case (ph_q)
			gccr_pkg::PH_RM_V, gccr_pkg::PH_RM_W: status.ph_kind = gccr_pkg::PK_REMOVE;
			gccr_pkg::PH_AP_V, gccr_pkg::PH_AP_W: status.ph_kind = gccr_pkg::PK_APPEND;
			gccr_pkg::PH_END:                     status.ph_kind = gccr_pkg::PK_DONE;
			default:                              status.ph_kind = gccr_pkg::PK_REBUILD;
		endcase
		status.top_empty   = (len_eff == '0) && (top_q != '0);
		status.held_zero   = held_q == '0;
		status.ec_last     = ec_q == top_q;
		status.out_free    = !res_vld_q || result_ready;
	end

	assign result_valid = res_vld_q;
	assign result       = res_q;

	`ASSERT_CLK(a_held_bound, clk, arst_n, held_q <= MAX_LEN)
	`ASSERT_CLK(a_place_room, clk, arst_n, (cmd.op == gccr_pkg::OP_PLACE) |-> (len_eff < MAX_LEN))
	`ASSERT_CLK(a_emit_class, clk, arst_n, (cmd.op == gccr_pkg::OP_EM_OUT) |-> (ec_q <= top_q))
	`ASSERT_NEVER(a_top_when_empty, clk, arst_n, (held_q == '0) && (top_q != '0))

endmodule
